FILE: rtl/core/sab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants
// Sizes, state encoding and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package sab_pkg;
    localparam int MaxLen    = 1024;
    localparam int Alphabet  = 26;
    localparam int MaxNodes  = 2 * MaxLen;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int CountW    = NodeW + 1;
    localparam int LenW      = $clog2(MaxLen + 1);
    localparam int SymW      = 5;
    localparam int TotW      = 20;
    localparam int EdgeDepth = MaxNodes * Alphabet;
    localparam int EdgeAW    = $clog2(EdgeDepth);
    localparam int ClearLen  = EdgeDepth;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_NEW, S_W1RD, S_W1WAIT, S_W1CHK, S_W1LINK,
        S_QRD, S_QWAIT, S_QCHK, S_CLSETUP, S_CPRD, S_CPWAIT, S_CPWR,
        S_W2RD, S_W2WAIT, S_W2CHK, S_FINRD, S_FINWAIT, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic start;
        logic mk_new;
        logic w1_set;
        logic p_adv;
        logic link_root;
        logic rd_q;
        logic link_q;
        logic clone_setup;
        logic cp_rd;
        logic cp_wr;
        logic w2_set;
        logic clone_fin;
        logic fin_rd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic p_none;
        logic edge_zero;
        logic edge_is_q;
        logic len_match;
        logic cp_last;
        logic full;
        logic sym_ok;
    } t_stat;
endpackage

FILE: rtl/core/sab_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_in_if / sab_out_if: valid/ready channels
// Carry the input symbol and the result payload, with source and sink views.
// ----------------------------------------------------------------------------
interface sab_in_if;
    logic                      valid;
    logic                      ready;
    logic [sab_pkg::SymW-1:0]  symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface sab_out_if;
    logic                        valid;
    logic                        ready;
    logic [sab_pkg::TotW-1:0]    distinct_substrings;
    logic [sab_pkg::CountW-1:0]  node_total;
    logic                        full_res;
    modport source (output valid, output distinct_substrings, output node_total,
                    output full_res, input ready);
    modport sink   (input valid, input distinct_substrings, input node_total,
                    input full_res, output ready);
endinterface

FILE: rtl/core/suffix_automaton_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder_unit: online suffix automaton construction
// Each symbol runs a new-node step, a suffix-link walk, an edge-target test and, on a
// clone, an edge copy and a redirecting link walk; a rejected symbol goes straight to the result.
// Throughput: one symbol at a time; the next is taken the cycle after the result.
// Reset: a clearing pass over the 53248-entry transition memory, during which
// no symbol is taken.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sab_in_if.sink    i_in,
    sab_out_if.source o_out
);
    sab_pkg::t_cmd  cmd;
    sab_pkg::t_stat stat;
    logic full;

    sab_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stat(stat),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_full(full), .o_cmd(cmd)
    );

    sab_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_symbol(i_in.symbol),
        .o_stat(stat), .o_total(o_out.distinct_substrings), .o_nodes(o_out.node_total)
    );

    assign o_out.full_res = full;
endmodule

FILE: rtl/core/sab_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_datapath: node tables and append arithmetic
// Holds length, link and transition memories and the walk registers.
// ----------------------------------------------------------------------------
module sab_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sab_pkg::t_cmd                i_cmd,
    input  logic [sab_pkg::SymW-1:0]     i_symbol,
    output sab_pkg::t_stat               o_stat,
    output logic [sab_pkg::TotW-1:0]     o_total,
    output logic [sab_pkg::CountW-1:0]   o_nodes
);
    localparam int NW = sab_pkg::NodeW;
    localparam int AW = sab_pkg::EdgeAW;

    logic [sab_pkg::LenW-1:0] len_mem [sab_pkg::MaxNodes];
    logic [NW:0]              link_mem [sab_pkg::MaxNodes];
    logic [NW-1:0]            edge_mem [sab_pkg::EdgeDepth];

    logic [NW-1:0]             r_cur, r_p, r_q, r_clone, r_last;
    logic                      r_p_none;
    logic [sab_pkg::SymW-1:0]  r_sym;
    logic [sab_pkg::CountW-1:0] r_used;
    logic [sab_pkg::TotW-1:0]  r_total;
    logic [sab_pkg::LenW-1:0]  r_text;
    logic [AW:0]               r_clr;
    logic [sab_pkg::SymW-1:0]  r_cpi;
    logic [NW-1:0]             r_edge;
    logic [sab_pkg::LenW-1:0]  r_len_p, r_len_q, r_len_cur, r_len_x;
    logic [NW:0]               r_link_p, r_link_q, r_link_cur;

    logic [AW-1:0] rd_addr, wr_addr;
    logic [NW-1:0] wr_data;
    logic          wr_en;
    logic [NW-1:0] rd_node;

    logic                     len_wr_en;
    logic [NW-1:0]            len_wr_addr;
    logic [sab_pkg::LenW-1:0] len_wr_data;
    logic                     link_wr_en;
    logic [NW-1:0]            link_wr_addr;
    logic [NW:0]              link_wr_data;

    function automatic logic [AW-1:0] eaddr(input logic [NW-1:0] n,
                                            input logic [sab_pkg::SymW-1:0] s);
        logic [AW+NW:0] t;
        t = ((AW+NW+1)'(n) * (AW+NW+1)'(sab_pkg::Alphabet)) + (AW+NW+1)'(s);
        return t[AW-1:0];
    endfunction

    always_comb begin
        rd_node = r_p;
        if (i_cmd.cp_rd) rd_node = r_q;
        rd_addr = eaddr(rd_node, i_cmd.cp_rd ? r_cpi : r_sym);
        wr_en   = 1'b0;
        wr_addr = eaddr(r_p, r_sym);
        wr_data = r_cur;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1; wr_addr = r_clr[AW-1:0]; wr_data = '0;
        end else if (i_cmd.w1_set) begin
            wr_en = 1'b1;
        end else if (i_cmd.w2_set) begin
            wr_en = 1'b1; wr_data = r_clone;
        end else if (i_cmd.cp_wr) begin
            wr_en = 1'b1; wr_addr = eaddr(r_clone, r_cpi); wr_data = r_edge;
        end
    end

    always_comb begin
        len_wr_en   = 1'b0;
        len_wr_addr = r_cur;
        len_wr_data = r_len_p + 1'b1;
        if (i_cmd.clr_step) begin
            len_wr_en = 1'b1; len_wr_addr = '0; len_wr_data = '0;
        end else if (i_cmd.mk_new) begin
            len_wr_en = 1'b1;
        end else if (i_cmd.clone_setup) begin
            len_wr_en = 1'b1; len_wr_addr = r_used[NW-1:0];
        end
    end

    always_comb begin
        link_wr_en   = 1'b0;
        link_wr_addr = r_cur;
        link_wr_data = {1'b1, {NW{1'b1}}};
        if (i_cmd.clr_step) begin
            link_wr_en = 1'b1; link_wr_addr = '0;
        end else if (i_cmd.mk_new) begin
            link_wr_en = 1'b1;
        end else if (i_cmd.clone_setup) begin
            link_wr_en = 1'b1; link_wr_addr = r_used[NW-1:0]; link_wr_data = r_link_q;
        end else if (i_cmd.clone_fin) begin
            link_wr_en = 1'b1; link_wr_addr = r_q; link_wr_data = {1'b0, r_clone};
        end else if (i_cmd.fin_rd) begin
            link_wr_en = 1'b1; link_wr_data = r_link_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) edge_mem[wr_addr] <= wr_data;
        if (len_wr_en) len_mem[len_wr_addr] <= len_wr_data;
        if (link_wr_en) link_mem[link_wr_addr] <= link_wr_data;
        r_edge <= edge_mem[rd_addr];
        r_len_p  <= len_mem[r_p];
        r_link_p <= link_mem[r_p];
        r_link_q <= link_mem[r_q];
        if (i_cmd.fin_rd) begin
            r_len_x <= len_mem[r_link_cur[NW-1:0]];
        end else begin
            r_len_q <= len_mem[r_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_used <= sab_pkg::CountW'(1); r_total <= '0; r_text <= '0;
            r_last <= '0; r_p_none <= 1'b0; r_cpi <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.start) begin
                r_sym <= i_symbol;
                r_cur <= r_used[NW-1:0];
                r_p <= r_last;
                r_p_none <= 1'b0;
            end
            if (i_cmd.mk_new) begin
                r_used <= r_used + 1'b1;
                r_len_cur <= r_len_p + 1'b1;
            end
            if (i_cmd.p_adv) begin
                r_p <= r_link_p[NW-1:0];
                r_p_none <= r_link_p[NW];
            end
            if (i_cmd.rd_q) r_q <= r_edge;
            if (i_cmd.link_root) r_link_cur <= '0;
            if (i_cmd.link_q) r_link_cur <= {1'b0, r_q};
            if (i_cmd.clone_setup) begin
                r_clone <= r_used[NW-1:0];
                r_used <= r_used + 1'b1;
                r_cpi <= '0;
            end
            if (i_cmd.cp_wr) r_cpi <= r_cpi + 1'b1;
            if (i_cmd.clone_fin) r_link_cur <= {1'b0, r_clone};
            if (i_cmd.fin) begin
                r_total <= r_total + sab_pkg::TotW'(r_len_cur - r_len_x);
                r_last <= r_cur;
                r_text <= r_text + 1'b1;
            end
        end
    end

    assign o_stat.clr_done  = (r_clr == (AW+1)'(sab_pkg::ClearLen - 1));
    assign o_stat.p_none    = r_p_none;
    assign o_stat.edge_zero = (r_edge == '0);
    assign o_stat.edge_is_q = (r_edge == r_q);
    assign o_stat.len_match = (r_len_p + 1'b1 == r_len_q);
    assign o_stat.cp_last   = (r_cpi == sab_pkg::SymW'(sab_pkg::Alphabet - 1));
    assign o_stat.full      = (r_text >= sab_pkg::LenW'(sab_pkg::MaxLen));
    assign o_stat.sym_ok    = (i_symbol < sab_pkg::SymW'(sab_pkg::Alphabet));
    assign o_total = r_total;
    assign o_nodes = r_used;
endmodule

FILE: rtl/core/sab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_ctrl: append sequencer
// Steps the datapath through new node, link walks, clone copy and result.
// ----------------------------------------------------------------------------
module sab_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sab_pkg::t_stat  i_stat,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_full,
    output sab_pkg::t_cmd   o_cmd
);
    sab_pkg::t_state r_state, n_state;
    logic r_full, n_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sab_pkg::S_CLEAR; r_full <= 1'b0;
        end else begin
            r_state <= n_state; r_full <= n_full;
        end
    end

    always_comb begin
        n_state = r_state;
        n_full = r_full;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sab_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = sab_pkg::S_IDLE;
            end
            sab_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_full = i_stat.full;
                    if (i_stat.full || !i_stat.sym_ok) begin
                        n_state = sab_pkg::S_OUT;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = sab_pkg::S_NEW;
                    end
                end
            end
            sab_pkg::S_NEW: n_state = sab_pkg::S_W1RD;
            sab_pkg::S_W1RD: begin
                o_cmd.mk_new = 1'b1;
                n_state = sab_pkg::S_W1WAIT;
            end
            sab_pkg::S_W1WAIT: n_state = sab_pkg::S_W1CHK;
            sab_pkg::S_W1CHK: begin
                if (i_stat.p_none) begin
                    o_cmd.link_root = 1'b1;
                    n_state = sab_pkg::S_FINRD;
                end else if (i_stat.edge_zero) begin
                    o_cmd.w1_set = 1'b1;
                    n_state = sab_pkg::S_W1LINK;
                end else begin
                    o_cmd.rd_q = 1'b1;
                    n_state = sab_pkg::S_QRD;
                end
            end
            sab_pkg::S_W1LINK: begin
                o_cmd.p_adv = 1'b1;
                n_state = sab_pkg::S_W1WAIT;
            end
            sab_pkg::S_QRD: n_state = sab_pkg::S_QWAIT;
            sab_pkg::S_QWAIT: n_state = sab_pkg::S_QCHK;
            sab_pkg::S_QCHK: begin
                if (i_stat.len_match) begin
                    o_cmd.link_q = 1'b1;
                    n_state = sab_pkg::S_FINRD;
                end else begin
                    o_cmd.clone_setup = 1'b1;
                    n_state = sab_pkg::S_CPRD;
                end
            end
            sab_pkg::S_CPRD: begin
                o_cmd.cp_rd = 1'b1;
                n_state = sab_pkg::S_CPWAIT;
            end
            sab_pkg::S_CPWAIT: begin
                o_cmd.cp_rd = 1'b1;
                n_state = sab_pkg::S_CPWR;
            end
            sab_pkg::S_CPWR: begin
                o_cmd.cp_wr = 1'b1;
                n_state = i_stat.cp_last ? sab_pkg::S_W2RD : sab_pkg::S_CPRD;
            end
            sab_pkg::S_W2RD: n_state = sab_pkg::S_W2WAIT;
            sab_pkg::S_W2WAIT: n_state = sab_pkg::S_W2CHK;
            sab_pkg::S_W2CHK: begin
                if (!i_stat.p_none && i_stat.edge_is_q) begin
                    o_cmd.w2_set = 1'b1;
                    o_cmd.p_adv = 1'b1;
                    n_state = sab_pkg::S_W2RD;
                end else begin
                    o_cmd.clone_fin = 1'b1;
                    n_state = sab_pkg::S_FINRD;
                end
            end
            sab_pkg::S_CLSETUP: n_state = sab_pkg::S_CPRD;
            sab_pkg::S_FINRD: begin
                o_cmd.fin_rd = 1'b1;
                n_state = sab_pkg::S_FINWAIT;
            end
            sab_pkg::S_FINWAIT: n_state = sab_pkg::S_FIN;
            sab_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = sab_pkg::S_OUT;
            end
            sab_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = sab_pkg::S_IDLE;
            end
            default: n_state = sab_pkg::S_IDLE;
        endcase
    end

    assign o_full = r_full;
endmodule

FILE: rtl/core/sab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_checker: port-level checks
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module sab_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sab_pkg::CountW-1:0]    i_node_total
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("input taken while result pending");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("second input taken");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
    a_nodes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_node_total != '0) else $error("node count zero");
endmodule

bind suffix_automaton_builder_unit sab_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_node_total(o_out.node_total)
);

FILE: tb/sv/suffix_automaton_builder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder_unit_tb: self-checking testbench
// Streams symbols into the builder and checks each transaction against a
// behavioral suffix automaton with its own node table, including overflow
// beyond the text limit and symbols outside the alphabet.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_unit_tb;
    localparam int LinkNone  = -1;
    localparam int CycleCap  = 3000000;

    typedef struct packed {
        logic [sab_pkg::TotW-1:0]   distinct_substrings;
        logic [sab_pkg::CountW-1:0] node_total;
        logic                       full_res;
    } t_totals;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sab_in_if  in_ch ();
    sab_out_if out_ch ();

    suffix_automaton_builder_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    int      sam_len  [sab_pkg::MaxNodes];
    int      sam_link [sab_pkg::MaxNodes];
    int      sam_next [sab_pkg::MaxNodes][sab_pkg::Alphabet];
    int      sam_used;
    int      sam_last;
    int      sam_total;
    int      sam_text;
    t_totals totals_q[$];
    int      fail_count = 0;
    int      cycles = 0;
    int      sent = 0;
    int      checked = 0;
    int      full_seen = 0;
    int      clone_seen = 0;
    int      stall_left = 0;

    task automatic sam_clear();
        for (int n = 0; n < sab_pkg::MaxNodes; n++) begin
            sam_len[n] = 0;
            sam_link[n] = 0;
            for (int c = 0; c < sab_pkg::Alphabet; c++) sam_next[n][c] = 0;
        end
        sam_link[0] = LinkNone;
        sam_used = 1;
        sam_last = 0;
        sam_total = 0;
        sam_text = 0;
    endtask

    task automatic sam_extend(input int sym);
        int cur;
        int p;
        int q;
        int cl;
        cur = sam_used;
        p = sam_last;
        sam_used++;
        sam_len[cur] = sam_len[sam_last] + 1;
        sam_link[cur] = LinkNone;
        for (int c = 0; c < sab_pkg::Alphabet; c++) sam_next[cur][c] = 0;
        while (p != LinkNone && sam_next[p][sym] == 0) begin
            sam_next[p][sym] = cur;
            p = sam_link[p];
        end
        if (p == LinkNone) begin
            sam_link[cur] = 0;
        end else begin
            q = sam_next[p][sym];
            if (sam_len[p] + 1 == sam_len[q]) begin
                sam_link[cur] = q;
            end else begin
                clone_seen++;
                cl = sam_used;
                sam_used++;
                sam_len[cl] = sam_len[p] + 1;
                sam_link[cl] = sam_link[q];
                for (int c = 0; c < sab_pkg::Alphabet; c++) sam_next[cl][c] = sam_next[q][c];
                while (p != LinkNone && sam_next[p][sym] == q) begin
                    sam_next[p][sym] = cl;
                    p = sam_link[p];
                end
                sam_link[q] = cl;
                sam_link[cur] = cl;
            end
        end
        sam_total += sam_len[cur] - sam_len[sam_link[cur]];
        sam_last = cur;
        sam_text++;
    endtask

    task automatic predict_totals(input logic [sab_pkg::SymW-1:0] sym);
        t_totals t;
        t.full_res = 1'b0;
        if (sam_text >= sab_pkg::MaxLen) begin
            t.full_res = 1'b1;
            full_seen++;
        end else if (sym < sab_pkg::Alphabet) begin
            sam_extend(int'(sym));
        end
        t.distinct_substrings = sab_pkg::TotW'(sam_total);
        t.node_total = sab_pkg::CountW'(sam_used);
        totals_q = {totals_q, t};
    endtask

    task automatic send_symbol(input logic [sab_pkg::SymW-1:0] sym);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.symbol <= sym;
        predict_totals(sym);
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (totals_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleCap) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_totals exp_t;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (totals_q.size() == 0) begin
                $error("unexpected transaction");
                fail_count++;
            end else begin
                exp_t = totals_q.pop_front();
                checked++;
                if (out_ch.distinct_substrings !== exp_t.distinct_substrings) begin
                    $error("distinct_substrings exp %0d got %0d",
                           exp_t.distinct_substrings, out_ch.distinct_substrings);
                    fail_count++;
                end
                if (out_ch.node_total !== exp_t.node_total) begin
                    $error("node_total exp %0d got %0d",
                           exp_t.node_total, out_ch.node_total);
                    fail_count++;
                end
                if (out_ch.full_res !== exp_t.full_res) begin
                    $error("full_res exp %0d got %0d", exp_t.full_res, out_ch.full_res);
                    fail_count++;
                end
            end
            stall_left = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) stall_left = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(sab_pkg::Alphabet - 1));
        send_symbol(sab_pkg::SymW'(sab_pkg::Alphabet));
        send_symbol(sab_pkg::SymW'(31));
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(1));
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(1));
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(0));
        send_symbol(sab_pkg::SymW'(sab_pkg::Alphabet - 1));
        send_symbol(sab_pkg::SymW'(16));
        send_symbol(sab_pkg::SymW'(15));
    endtask

    task automatic test_small_alphabet();
        // keep clones frequent with a narrow alphabet
        for (int i = 0; i < 700; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_symbol(sab_pkg::SymW'($urandom_range(26, 31)));
            end else begin
                send_symbol(sab_pkg::SymW'($urandom_range(0, 2)));
            end
        end
        drain();
    endtask

    task automatic test_fill_to_limit();
        while (sam_text < sab_pkg::MaxLen) send_symbol(sab_pkg::SymW'($urandom_range(0, 31)));
    endtask

    task automatic test_full_reject();
        for (int i = 0; i < 400; i++) send_symbol(sab_pkg::SymW'($urandom_range(0, 31)));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.symbol = '0;
        sam_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_small_alphabet();
        test_fill_to_limit();
        test_full_reject();
        drain();
        $display("Sent %0d symbols, checked %0d transactions, %0d clones, %0d rejected full.",
                 sent, checked, clone_seen, full_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/core/sab_pkg.sv
rtl/core/sab_if.sv
rtl/core/sab_datapath.sv
rtl/core/sab_ctrl.sv
rtl/core/suffix_automaton_builder_unit.sv
rtl/core/sab_checker.sv
tb/sv/suffix_automaton_builder_unit_tb.sv
